// File: hw/rtl/bsp_pkg.sv
// shared types and constants of the battery storage plant step block
// no dependencies; imported by every module of the block
package bsp_pkg;

	localparam int COEF_BITS = 30;
	localparam int GAIN_BITS = 24;

	localparam logic [2:0] REG_POWER_MAX      = 3'd0;
	localparam logic [2:0] REG_POWER_MIN      = 3'd1;
	localparam logic [2:0] REG_LAG_STATE_COEF = 3'd2;
	localparam logic [2:0] REG_LAG_INPUT_COEF = 3'd3;
	localparam logic [2:0] REG_CHARGE_FLOOR   = 3'd4;
	localparam logic [2:0] REG_CHARGE_CEILING = 3'd5;
	localparam logic [2:0] REG_DISCHARGE_GAIN = 3'd6;
	localparam logic [2:0] REG_RECHARGE_GAIN  = 3'd7;

	typedef struct packed {
		logic signed [31:0] power_max;
		logic signed [31:0] power_min;
		logic signed [31:0] lag_state_coef;
		logic signed [31:0] lag_input_coef;
		logic [22:0]        charge_floor;
		logic [22:0]        charge_ceiling;
		logic [31:0]        discharge_gain;
		logic [31:0]        recharge_gain;
	} cfg_t;

	typedef struct packed {
		logic [22:0]        charge_now;
		logic signed [31:0] power_now;
		logic signed [31:0] power_request;
		logic signed [31:0] load_power;
		logic signed [31:0] source_limit;
		logic               grid_up;
	} step_in_t;

	// lagged power with the fields still needed downstream
	typedef struct packed {
		logic [22:0]        charge;
		logic signed [31:0] power;
		logic signed [31:0] load;
		logic signed [31:0] limit;
		logic               grid;
	} lag_out_t;

	typedef struct packed {
		logic [22:0]        charge;
		logic signed [31:0] power;
		logic signed [31:0] source;
		logic [30:0]        unserved;
	} grid_out_t;

	typedef struct packed {
		logic signed [31:0] power_next;
		logic signed [31:0] source_power;
		logic [30:0]        unserved_power;
		logic [22:0]        charge_next;
	} step_out_t;

endpackage

// File: hw/rtl/bsp_lag.sv
// request clamp and first-order power lag, three pipeline stages
// depends on bsp_pkg
module bsp_lag import bsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  step_in_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output lag_out_t out_data
);

	localparam logic signed [64:0] LAG_HALF = 65'sd1 <<< (COEF_BITS - 1);

	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3 = !v_s3 || out_ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1: clamp request, upper limit first
	logic signed [31:0] req_hi, req_lim;
	assign req_hi  = (in_data.power_request > cfg.power_max) ? cfg.power_max
	                                                         : in_data.power_request;
	assign req_lim = (req_hi < cfg.power_min) ? cfg.power_min : req_hi;

	step_in_t           item_s1;
	logic signed [31:0] req_s1;
	lag_out_t           pass_s2;
	logic signed [63:0] prod_state_s2, prod_input_s2;

	// stage 3: round half up and saturate
	logic signed [64:0] lag_sum;
	logic signed [64:0] lag_shift;
	logic signed [31:0] lag_sat;
	assign lag_sum   = 65'(prod_state_s2) + 65'(prod_input_s2) + LAG_HALF;
	assign lag_shift = lag_sum >>> COEF_BITS;
	always_comb begin
		lag_sat = lag_shift[31:0];
		if (lag_shift[34:31] != {4{lag_shift[31]}}) begin
			lag_sat = lag_shift[34] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			item_s1 <= in_data;
			req_s1  <= req_lim;
		end
		if (adv_s2) begin
			prod_state_s2  <= cfg.lag_state_coef * item_s1.power_now;
			prod_input_s2  <= cfg.lag_input_coef * req_s1;
			pass_s2.charge <= item_s1.charge_now;
			pass_s2.power  <= '0;
			pass_s2.load   <= item_s1.load_power;
			pass_s2.limit  <= item_s1.source_limit;
			pass_s2.grid   <= item_s1.grid_up;
		end
		if (adv_s3) begin
			out_data.charge <= pass_s2.charge;
			out_data.power  <= lag_sat;
			out_data.load   <= pass_s2.load;
			out_data.limit  <= pass_s2.limit;
			out_data.grid   <= pass_s2.grid;
		end
	end

	assign out_valid = v_s3;

endmodule

// File: hw/rtl/bsp_grid.sv
// power limits, empty and full gating, grid source and unserved load
// depends on bsp_pkg; three pipeline stages
module bsp_grid import bsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  lag_out_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output grid_out_t out_data
);

	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3 = !v_s3 || out_ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1: clamp again, then gate on empty or full battery
	logic signed [31:0] p_hi, p_lim, p_gate;
	always_comb begin
		p_hi   = (in_data.power > cfg.power_max) ? cfg.power_max : in_data.power;
		p_lim  = (p_hi < cfg.power_min) ? cfg.power_min : p_hi;
		p_gate = p_lim;
		if (in_data.charge <= cfg.charge_floor && p_lim > 32'sd0) p_gate = '0;
		if (in_data.charge >= cfg.charge_ceiling && p_lim < 32'sd0) p_gate = '0;
	end

	lag_out_t item_s1, item_s2;

	// stage 2: grid source, clamped to limit then floored at zero
	logic signed [32:0] src_diff, src_hi;
	logic signed [31:0] src_val;
	always_comb begin
		src_diff = item_s1.grid ? (33'(item_s1.load) - 33'(item_s1.power)) : '0;
		src_hi   = (src_diff > 33'(item_s1.limit)) ? 33'(item_s1.limit) : src_diff;
		src_val  = src_hi[32] ? '0 : src_hi[31:0];
	end

	logic signed [31:0] src_s2;

	// stage 3: unserved load, floored and capped
	logic signed [33:0] uns_diff;
	logic [30:0]        uns_val;
	always_comb begin
		uns_diff = 34'(item_s2.load) - 34'(src_s2) - 34'(item_s2.power);
		if (uns_diff[33]) begin
			uns_val = '0;
		end else if (uns_diff[32:31] != 2'b00) begin
			uns_val = '1;
		end else begin
			uns_val = uns_diff[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			item_s1.charge <= in_data.charge;
			item_s1.power  <= p_gate;
			item_s1.load   <= in_data.load;
			item_s1.limit  <= in_data.limit;
			item_s1.grid   <= in_data.grid;
		end
		if (adv_s2) begin
			item_s2 <= item_s1;
			src_s2  <= src_val;
		end
		if (adv_s3) begin
			out_data.charge   <= item_s2.charge;
			out_data.power    <= item_s2.power;
			out_data.source   <= src_s2;
			out_data.unserved <= uns_val;
		end
	end

	assign out_valid = v_s3;

endmodule

// File: hw/rtl/bsp_charge.sv
// state of charge update: gain select, multiply, round, add, clamp
// depends on bsp_pkg; five pipeline stages, the last one is the output register
module bsp_charge import bsp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  grid_out_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output step_out_t out_data
);

	localparam longint FULL_RAW = longint'(100) << FRAC_BITS;
	localparam logic [22:0] FULL_CHARGE = (FULL_RAW > longint'(23'h7FFFFF)) ? 23'h7FFFFF
	                                                                       : 23'(FULL_RAW);
	localparam logic [64:0] GAIN_HALF = 65'd1 << (GAIN_BITS - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	assign adv_s5 = !v_s5 || out_ready;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	grid_out_t   item_s1, item_s2, item_s3, item_s4;
	logic        neg_s1, neg_s2, neg_s3;
	logic [31:0] mag_s1, gain_s1;
	logic [63:0] prod_s2;
	logic [40:0] delta_s3;
	logic signed [42:0] next_s4;

	logic        neg_in;
	logic [31:0] mag_in;
	assign neg_in = in_data.power[31];
	assign mag_in = neg_in ? (~in_data.power + 32'd1) : in_data.power;

	logic [64:0] delta_sum;
	assign delta_sum = 65'(prod_s2) + GAIN_HALF;

	logic [42:0] charge_ext, delta_ext;
	assign charge_ext = {20'd0, item_s3.charge};
	assign delta_ext  = {2'd0, delta_s3};

	// ceiling first, floor wins, then the full mark and zero
	logic signed [42:0] n_hi, n_lo, n_full;
	logic [22:0]        n_out;
	always_comb begin
		n_hi   = (next_s4 > $signed({20'd0, cfg.charge_ceiling})) ?
		         $signed({20'd0, cfg.charge_ceiling}) : next_s4;
		n_lo   = (n_hi < $signed({20'd0, cfg.charge_floor})) ?
		         $signed({20'd0, cfg.charge_floor}) : n_hi;
		n_full = (n_lo > $signed({20'd0, FULL_CHARGE})) ? $signed({20'd0, FULL_CHARGE}) : n_lo;
		n_out  = n_full[42] ? '0 : n_full[22:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			item_s1 <= in_data;
			neg_s1  <= neg_in;
			mag_s1  <= mag_in;
			gain_s1 <= neg_in ? cfg.recharge_gain : cfg.discharge_gain;
		end
		if (adv_s2) begin
			item_s2 <= item_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= mag_s1 * gain_s1;
		end
		if (adv_s3) begin
			item_s3  <= item_s2;
			neg_s3   <= neg_s2;
			delta_s3 <= delta_sum[64:GAIN_BITS];
		end
		if (adv_s4) begin
			item_s4 <= item_s3;
			next_s4 <= neg_s3 ? $signed(charge_ext + delta_ext) : $signed(charge_ext - delta_ext);
		end
		if (adv_s5) begin
			out_data.power_next     <= item_s4.power;
			out_data.source_power   <= item_s4.source;
			out_data.unserved_power <= item_s4.unserved;
			out_data.charge_next    <= n_out;
		end
	end

	assign out_valid = v_s5;

endmodule

// File: hw/rtl/battery_storage_plant_step.sv
// top level of the battery storage plant step: config registers and the pipeline
// depends on bsp_pkg, bsp_lag, bsp_grid and bsp_charge
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata (step inputs), s_tuser (grid_up)
//  m_*       out  m_tvalid/m_tready   m_tdata (step results)
//  cfg_*     in   cfg_we              cfg_index, cfg_data
//
// one beat in per cycle unless a stall at m_tready backs up to the input
// depth is set by multipliers and wide steps: lag products share a stage, as
// do lag round and saturate; gain multiply, round, add and clamp get one each
// every stage holds its beat while the next one is full and stalled, and an empty
// stage takes a new beat, so bubbles close up behind a stalled output
// arst_n clears the valid bits and loads the config reset values
module battery_storage_plant_step import bsp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// fields from bit 0: charge_now[22:0], power_now[54:23], power_request[86:55],
	// load_power[118:87], source_limit[150:119], zero pad [151]
	input  logic [151:0] s_tdata,
	// fields from bit 0: grid_up[0]
	input  logic         s_tuser,
	input  logic         s_tvalid,
	output logic         s_tready,
	// fields from bit 0: power_next[31:0], source_power[63:32],
	// unserved_power[94:64], charge_next[117:95], zero pad [119:118]
	output logic [119:0] m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cfg_t cfg_q;

	// config writes are registered, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_max      <= '0;
			cfg_q.power_min      <= '0;
			cfg_q.lag_state_coef <= '0;
			cfg_q.lag_input_coef <= 32'sh40000000;
			cfg_q.charge_floor   <= '0;
			cfg_q.charge_ceiling <= 23'd6553600;
			cfg_q.discharge_gain <= '0;
			cfg_q.recharge_gain  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POWER_MAX:      cfg_q.power_max      <= cfg_data;
				REG_POWER_MIN:      cfg_q.power_min      <= cfg_data;
				REG_LAG_STATE_COEF: cfg_q.lag_state_coef <= cfg_data;
				REG_LAG_INPUT_COEF: cfg_q.lag_input_coef <= cfg_data;
				REG_CHARGE_FLOOR:   cfg_q.charge_floor   <= cfg_data[22:0];
				REG_CHARGE_CEILING: cfg_q.charge_ceiling <= cfg_data[22:0];
				REG_DISCHARGE_GAIN: cfg_q.discharge_gain <= cfg_data;
				REG_RECHARGE_GAIN:  cfg_q.recharge_gain  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// unpack the input beat
	step_in_t in_item;
	assign in_item.charge_now    = s_tdata[22:0];
	assign in_item.power_now     = s_tdata[54:23];
	assign in_item.power_request = s_tdata[86:55];
	assign in_item.load_power    = s_tdata[118:87];
	assign in_item.source_limit  = s_tdata[150:119];
	assign in_item.grid_up       = s_tuser;

	lag_out_t  lag_data;
	logic      lag_valid, lag_ready;
	grid_out_t grid_data;
	logic      grid_valid, grid_ready;
	step_out_t out_item;

	// stages 1-3: request clamp, lag products, rounding and saturation
	bsp_lag u_lag (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (in_item),
		.out_valid (lag_valid),
		.out_ready (lag_ready),
		.out_data  (lag_data)
	);

	// stages 4-6: limits and gating, grid source, unserved load
	bsp_grid u_grid (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (lag_valid),
		.in_ready  (lag_ready),
		.in_data   (lag_data),
		.out_valid (grid_valid),
		.out_ready (grid_ready),
		.out_data  (grid_data)
	);

	// stages 7-11: charge update, last stage is the output register
	bsp_charge #(
		.FRAC_BITS (FRAC_BITS)
	) u_charge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (grid_valid),
		.in_ready  (grid_ready),
		.in_data   (grid_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_item)
	);

	// pack the result beat
	assign m_tdata = {2'b00, out_item.charge_next, out_item.unserved_power,
	                  out_item.source_power, out_item.power_next};

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for battery_storage_plant_step: directed vectors, then random steps under random
// register settings, results checked against typed values or a fixed-point plant predictor
// depends on bsp_pkg and the battery_storage_plant_step rtl
module tb_top import bsp_pkg::*; ();

	localparam int FRAC_BITS       = 16;
	localparam int PIPE_DEPTH      = 11;      // input beat to result beat
	localparam int RAND_PHASES     = 7;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int LIMIT_CYCLES    = 400000;
	localparam int NUM_VECTORS     = 23;

	localparam logic signed [79:0] WORD_HI = (80'sd1 <<< 31) - 80'sd1;
	localparam logic signed [79:0] WORD_LO = -(80'sd1 <<< 31);
	localparam int SOC_CAP     = 8388607;
	localparam int SOC_FULL    = ((100 << FRAC_BITS) > SOC_CAP) ? SOC_CAP : (100 << FRAC_BITS);
	localparam int SOC_HUNDRED = 6553600;

	localparam cfg_t RESET_CFG = '{32'd0, 32'd0, 32'd0, 32'h40000000,
		23'd0, 23'd6553600, 32'd0, 32'd0};

	// one directed row: which register set it runs under, the stimulus, and an
	// optional hand-typed result (otherwise the predictor supplies it)
	typedef struct packed {
		logic [1:0] cfg_sel;
		step_in_t   stim;
		logic       typed;
		step_out_t  want;
	} vector_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [151:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] m_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	cfg_t      plant_cfg = RESET_CFG;   // bench copy of the register file
	step_out_t pending_results[$];      // predicted results, oldest first
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        stall_left = 0;
	logic      idling_on = 1'b1;

	cfg_t    vector_cfg [4];
	vector_t vectors [NUM_VECTORS];

	battery_storage_plant_step #(.FRAC_BITS(FRAC_BITS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one plant step, done in wide signed arithmetic so no intermediate can wrap
	function automatic step_out_t plant_step_model(input cfg_t c, input step_in_t x);
		logic signed [79:0] pmax, pmin, req, lag, p, load, limit, src, unserved;
		logic signed [79:0] soc, floor_v, ceil_v, next_soc;
		logic [79:0] mag, gain, delta;
		step_out_t r;
		pmax    = $signed(c.power_max);
		pmin    = $signed(c.power_min);
		load    = $signed(x.load_power);
		limit   = $signed(x.source_limit);
		soc     = $signed({57'd0, x.charge_now});
		floor_v = $signed({57'd0, c.charge_floor});
		ceil_v  = $signed({57'd0, c.charge_ceiling});

		// request clamp: upper bound first, so crossed limits give power_min
		req = $signed(x.power_request);
		if (req > pmax) req = pmax;
		if (req < pmin) req = pmin;

		// first-order lag, round half up at the Q2.30 point, saturate to a word
		lag = $signed(c.lag_state_coef) * $signed(x.power_now)
			+ $signed(c.lag_input_coef) * req + (80'sd1 <<< (COEF_BITS - 1));
		p = lag >>> COEF_BITS;
		if (p > WORD_HI) p = WORD_HI;
		if (p < WORD_LO) p = WORD_LO;
		if (p > pmax) p = pmax;
		if (p < pmin) p = pmin;

		// empty battery cannot discharge, full battery cannot charge
		if (soc <= floor_v && p > 0) p = 0;
		if (soc >= ceil_v && p < 0) p = 0;

		if (x.grid_up) src = load - p;
		else src = 0;
		if (src > limit) src = limit;
		if (src < 0) src = 0;

		unserved = load - src - p;
		if (unserved < 0) unserved = 0;
		if (unserved > WORD_HI) unserved = WORD_HI;

		// zero power takes the discharge gain, which moves nothing
		if (p >= 0) begin
			mag  = p;
			gain = {48'd0, c.discharge_gain};
		end else begin
			mag  = -p;
			gain = {48'd0, c.recharge_gain};
		end
		delta = (mag * gain + (80'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
		if (p >= 0) next_soc = soc - $signed(delta);
		else next_soc = soc + $signed(delta);
		// ceiling then floor, so a crossed floor wins
		if (next_soc > ceil_v) next_soc = ceil_v;
		if (next_soc < floor_v) next_soc = floor_v;
		if (next_soc > SOC_FULL) next_soc = SOC_FULL;
		if (next_soc < 0) next_soc = 0;

		r.power_next     = p[31:0];
		r.source_power   = src[31:0];
		r.unserved_power = unserved[30:0];
		r.charge_next    = next_soc[22:0];
		return r;
	endfunction

	// word biased toward the corners of the signed range
	function automatic logic [31:0] corner_word();
		case ($urandom_range(0, 7))
			0: return 32'h00000000;
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			3: return 32'hFFFFFFFF;
			4: return 32'h00000001;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [22:0] random_soc(input cfg_t c);
		case ($urandom_range(0, 15))
			0, 1: return c.charge_floor;
			2, 3: return c.charge_ceiling;
			4: return 23'd0;
			5: return 23'(SOC_HUNDRED);
			default: return 23'($urandom_range(0, SOC_HUNDRED));
		endcase
	endfunction

	// mode 0 is a plausible plant, mode 1 corners, mode 2 raw words with charge limits up to SOC_HUNDRED
	function automatic cfg_t random_config(input int mode);
		cfg_t c;
		int unsigned a;
		int unsigned lo;
		int unsigned hi;
		case (mode)
			0: begin
				c.power_max      = int'($urandom_range(0, 200 << 16));
				c.power_min      = -int'($urandom_range(0, 200 << 16));
				a                = $urandom_range(0, 1 << 30);
				c.lag_state_coef = int'(a);
				c.lag_input_coef = int'((1 << 30) - a);
				lo               = $urandom_range(0, SOC_HUNDRED / 2);
				hi               = $urandom_range(SOC_HUNDRED / 2, SOC_HUNDRED);
				c.charge_floor   = 23'(lo);
				c.charge_ceiling = 23'(hi);
				c.discharge_gain = $urandom_range(0, 1 << 22);
				c.recharge_gain  = $urandom_range(0, 1 << 22);
			end
			1: begin
				c.power_max      = corner_word();
				c.power_min      = corner_word();
				c.lag_state_coef = corner_word();
				c.lag_input_coef = corner_word();
				c.charge_floor   = ($urandom_range(0, 1) != 0) ? 23'd0 : 23'(SOC_HUNDRED);
				c.charge_ceiling = ($urandom_range(0, 1) != 0) ? 23'd0 : 23'(SOC_HUNDRED);
				c.discharge_gain = corner_word();
				c.recharge_gain  = corner_word();
			end
			default: begin
				c.power_max      = $urandom();
				c.power_min      = $urandom();
				c.lag_state_coef = $urandom();
				c.lag_input_coef = $urandom();
				c.charge_floor   = 23'($urandom_range(0, SOC_HUNDRED));
				c.charge_ceiling = 23'($urandom_range(0, SOC_HUNDRED));
				c.discharge_gain = $urandom();
				c.recharge_gain  = $urandom();
			end
		endcase
		return c;
	endfunction

	// wild steps use raw words, tame ones stay in a realistic operating window
	function automatic step_in_t random_step(input cfg_t c, input bit wild);
		step_in_t x;
		x.charge_now = random_soc(c);
		if (wild) begin
			x.power_now     = corner_word();
			x.power_request = corner_word();
			x.load_power    = corner_word();
			x.source_limit  = corner_word();
			x.grid_up       = 1'($urandom_range(0, 1));
		end else begin
			x.power_now     = int'($urandom_range(0, 39321600)) - 19660800;
			x.power_request = int'($urandom_range(0, 39321600)) - 19660800;
			x.load_power    = int'($urandom_range(0, 500 << 16));
			if ($urandom_range(0, 7) == 0) x.source_limit = -int'($urandom_range(0, 1 << 20));
			else x.source_limit = int'($urandom_range(0, 500 << 16));
			x.grid_up       = ($urandom_range(0, 7) != 0);
		end
		return x;
	endfunction

	task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// only called with the pipeline empty; write enable stays high across the burst
	task automatic load_config(input cfg_t c);
		put_reg(REG_POWER_MAX,      c.power_max);
		put_reg(REG_POWER_MIN,      c.power_min);
		put_reg(REG_LAG_STATE_COEF, c.lag_state_coef);
		put_reg(REG_LAG_INPUT_COEF, c.lag_input_coef);
		put_reg(REG_CHARGE_FLOOR,   {9'd0, c.charge_floor});
		put_reg(REG_CHARGE_CEILING, {9'd0, c.charge_ceiling});
		put_reg(REG_DISCHARGE_GAIN, c.discharge_gain);
		put_reg(REG_RECHARGE_GAIN,  c.recharge_gain);
		cfg_we    <= 1'b0;
		plant_cfg = c;
		@(posedge clk);
	endtask

	// present one input beat, hold it until accepted, then log what should come out
	task automatic send_step(input step_in_t x, input logic typed, input step_out_t want);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {1'b0, x.source_limit, x.load_power, x.power_request,
			x.power_now, x.charge_now};
		s_tuser  <= x.grid_up;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (typed) pending_results.push_back(want);
		else pending_results.push_back(plant_step_model(plant_cfg, x));
	endtask

	// drop valid, let every predicted result come out, then let the pipe settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	// output side: random stall bursts while idling is on, otherwise always ready
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= (stall_left == 1);
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 16);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker: every output beat is matched against the oldest prediction
	always @(posedge clk) begin
		step_out_t got;
		step_out_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got.power_next     = m_tdata[31:0];
			got.source_power   = m_tdata[63:32];
			got.unserved_power = m_tdata[94:64];
			got.charge_next    = m_tdata[117:95];
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				mismatch_count = mismatch_count + 1;
			end else begin
				exp_r = pending_results.pop_front();
				if (got.power_next !== exp_r.power_next) begin
					$error("power_next mismatch: expected %0d, actual %0d",
						$signed(exp_r.power_next), $signed(got.power_next));
					mismatch_count = mismatch_count + 1;
				end
				if (got.source_power !== exp_r.source_power) begin
					$error("source_power mismatch: expected %0d, actual %0d",
						$signed(exp_r.source_power), $signed(got.source_power));
					mismatch_count = mismatch_count + 1;
				end
				if (got.unserved_power !== exp_r.unserved_power) begin
					$error("unserved_power mismatch: expected %0d, actual %0d",
						exp_r.unserved_power, got.unserved_power);
					mismatch_count = mismatch_count + 1;
				end
				if (got.charge_next !== exp_r.charge_next) begin
					$error("charge_next mismatch: expected %0d, actual %0d",
						exp_r.charge_next, got.charge_next);
					mismatch_count = mismatch_count + 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int cur_sel;

		// register sets for the directed rows: reset values, corners, a plausible
		// plant with half-way lag weights, and crossed power and charge limits
		vector_cfg[0] = RESET_CFG;
		vector_cfg[1] = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
			23'd0, 23'd6553600, 32'hFFFFFFFF, 32'hFFFFFFFF};
		vector_cfg[2] = '{32'd3276800, 32'hFFE20000, 32'h20000000, 32'h20000000,
			23'd655360, 23'd5898240, 32'd1677722, 32'd1258291};
		vector_cfg[3] = '{32'hFFFE7960, 32'h00030D40, 32'd0, 32'h40000000,
			23'd5898240, 23'd655360, 32'h01000000, 32'h00800000};

		// after reset the power limits are both zero, so power stays zero and the
		// results can be typed in directly
		vectors[0]  = '{2'd0, '{23'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00640000,
			32'h7FFFFFFF, 1'b1}, 1'b1, '{32'd0, 32'h00640000, 31'd0, 23'd0}};
		// grid down: all load unserved
		vectors[1]  = '{2'd0, '{23'd6553600, 32'h80000000, 32'h80000000, 32'h00640000,
			32'h7FFFFFFF, 1'b0}, 1'b1, '{32'd0, 32'd0, 31'd6553600, 23'd6553600}};
		// unserved at its top value
		vectors[2]  = '{2'd0, '{23'h3FFFFF, 32'h12345678, 32'hEDCBA987, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1'b0}, 1'b1, '{32'd0, 32'd0, 31'h7FFFFFFF, 23'h3FFFFF}};
		// negative load: source and unserved both floored at zero
		vectors[3]  = '{2'd0, '{23'd1, 32'd0, 32'd0, 32'h80000000,
			32'h7FFFFFFF, 1'b1}, 1'b1, '{32'd0, 32'd0, 31'd0, 23'd1}};
		// source capped by its limit
		vectors[4]  = '{2'd0, '{23'd100, 32'd0, 32'd0, 32'h7FFFFFFF,
			32'd1000, 1'b1}, 1'b1, '{32'd0, 32'd1000, 31'd2147482647, 23'd100}};
		// negative source limit gives no source
		vectors[5]  = '{2'd0, '{23'd6553600, 32'd0, 32'd0, 32'd50,
			32'hFFFFFFFB, 1'b1}, 1'b1, '{32'd0, 32'd0, 31'd50, 23'd6553600}};
		vectors[6]  = '{2'd0, '{23'h555555, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
			32'h55555555, 1'b1}, 1'b1, '{32'd0, 32'h55555555, 31'd0, 23'h555555}};
		// lag sum past the word range, both directions
		vectors[7]  = '{2'd1, '{23'd3276800, 32'h80000000, 32'h80000000, 32'd0,
			32'h7FFFFFFF, 1'b1}, 1'b0, '0};
		vectors[8]  = '{2'd1, '{23'd3276800, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 1'b1}, 1'b0, '0};
		// empty and discharging, full and charging
		vectors[9]  = '{2'd1, '{23'd0, 32'h80000000, 32'd0, 32'h00100000,
			32'h7FFFFFFF, 1'b1}, 1'b0, '0};
		vectors[10] = '{2'd1, '{23'd6553600, 32'h7FFFFFFF, 32'd0, 32'd0,
			32'd0, 1'b0}, 1'b0, '0};
		vectors[11] = '{2'd1, '{23'd3276800, 32'd0, 32'hFFFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1'b1}, 1'b0, '0};
		vectors[12] = '{2'd1, '{23'd1, 32'hFFFFFFFF, 32'd0, 32'h80000000,
			32'h7FFFFFFF, 1'b0}, 1'b0, '0};
		// request above the upper and below the lower limit
		vectors[13] = '{2'd2, '{23'd3276800, 32'd1, 32'h00640000, 32'h00500000,
			32'h00200000, 1'b1}, 1'b0, '0};
		vectors[14] = '{2'd2, '{23'd3276800, 32'hFFFFFFFF, 32'h80000000, 32'h00100000,
			32'h7FFFFFFF, 1'b1}, 1'b0, '0};
		// charge exactly at floor and at ceiling
		vectors[15] = '{2'd2, '{23'd655360, 32'h00100000, 32'h00100000, 32'd0,
			32'd0, 1'b1}, 1'b0, '0};
		vectors[16] = '{2'd2, '{23'd5898240, 32'hFFF00000, 32'hFFF00000, 32'h00010000,
			32'h00010000, 1'b1}, 1'b0, '0};
		// lag rounding ties on either side of zero
		vectors[17] = '{2'd2, '{23'd3000000, 32'd3, 32'd0, 32'h00050000,
			32'h00100000, 1'b0}, 1'b0, '0};
		vectors[18] = '{2'd2, '{23'd3000000, 32'hFFFFFFFD, 32'd0, 32'd0,
			32'hFFFFFFFF, 1'b1}, 1'b0, '0};
		vectors[19] = '{2'd2, '{23'd6553600, 32'h00123456, 32'h00FEDCBA, 32'h01000000,
			32'h00800000, 1'b1}, 1'b0, '0};
		// crossed power limits and crossed charge limits
		vectors[20] = '{2'd3, '{23'd3276800, 32'd0, 32'h00100000, 32'h00100000,
			32'h00080000, 1'b1}, 1'b0, '0};
		vectors[21] = '{2'd3, '{23'd0, 32'd0, 32'h80000000, 32'h00100000,
			32'h7FFFFFFF, 1'b1}, 1'b0, '0};
		vectors[22] = '{2'd3, '{23'd6553600, 32'd0, 32'h7FFFFFFF, 32'd0,
			32'd0, 1'b0}, 1'b0, '0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, first rows run on the reset register values
		cur_sel = 0;
		foreach (vectors[i]) begin
			if (vectors[i].cfg_sel != cur_sel) begin
				wait_idle();
				cur_sel = vectors[i].cfg_sel;
				load_config(vector_cfg[cur_sel]);
			end
			send_step(vectors[i].stim, vectors[i].typed, vectors[i].want);
		end

		// random part, a fresh register set per phase; the last phase runs flat out
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			idling_on <= (ph != RAND_PHASES - 1);
			load_config(random_config(ph % 3));
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_step(random_step(plant_cfg, $urandom_range(0, 3) == 0), 1'b0, '0);
		end
		wait_idle();

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/bsp_pkg.sv
hw/rtl/bsp_lag.sv
hw/rtl/bsp_grid.sv
hw/rtl/bsp_charge.sv
hw/rtl/battery_storage_plant_step.sv
sim/tb_top.sv
